// ===== hw/rtl/dbt_pkg.sv =====
`timescale 1ns / 1ps

package dbt_pkg;

    localparam int DEPTH  = 64;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_UPD  = 2'd1;
    localparam logic [1:0] REQ_SCAN = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        inode_num;
        logic [31:0]        block_num;
        logic signed [31:0] block_index;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic               entry_valid;
        logic [31:0]        entry_inode;
        logic [31:0]        entry_block;
        logic signed [31:0] entry_index;
        logic               last;
        logic [6:0]         entry_count;
    } t_res;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_UPD  = 2'd1,
        OP_SCAN = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef struct packed {
        logic [31:0] inode;
        logic [31:0] block;
        logic [31:0] index;
    } t_rec;

    typedef struct packed {
        t_op  op;
        t_rec rec;
    } t_cmd;

endpackage

// ===== hw/rtl/dbt_front.sv =====
`timescale 1ns / 1ps

module dbt_front import dbt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_q_valid,
    output t_cmd o_q_cmd,
    input  logic i_q_pop
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_fill;
    t_cmd       n_cmd;
    logic       push;

    always_comb begin
        n_cmd.rec.inode = i_req.inode_num;
        n_cmd.rec.block = i_req.block_num;
        n_cmd.rec.index = i_req.block_index;
        unique case (i_req.req_type)
            REQ_ADD:  n_cmd.op = OP_ADD;
            REQ_UPD:  n_cmd.op = OP_UPD;
            REQ_SCAN: n_cmd.op = OP_SCAN;
            default:  n_cmd.op = OP_NOP;
        endcase
    end

    assign busy      = (r_fill == 2'd2);
    assign push      = start && !busy;
    assign o_q_valid = (r_fill != 2'd0);
    assign o_q_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_fill <= r_fill + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

// ===== hw/rtl/dbt_back.sv =====
`timescale 1ns / 1ps

module dbt_back import dbt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cmd i_q_cmd,
    output logic o_q_pop,
    output logic o_done,
    output t_res o_result
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_UPD_CHK = 8'b0000_0010,
        S_SRT_KEY = 8'b0000_0100,
        S_SRT_CMP = 8'b0000_1000,
        S_SRT_PUT = 8'b0001_0000,
        S_SCN_OUT = 8'b0010_0000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt, r_i, n_i, r_j, n_j, r_k, n_k;
    logic r_sorted, n_sorted;
    t_rec r_key, n_key, r_cmd_rec, r_rd;
    t_rec mem [DEPTH];
    logic rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    t_rec wr_data;
    logic r_done, n_done;
    t_res r_res, n_res;
    logic [CNT_W-1:0] i_nx;

    function automatic logic rec_after(t_rec x, t_rec y);
        return {x.block, x.inode, ~x.index[31], x.index[30:0]} >
               {y.block, y.inode, ~y.index[31], y.index[30:0]};
    endfunction

    assign i_nx = r_i + 1'b1;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_sorted = r_sorted;
        n_key    = r_key;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = r_key;
        o_q_pop  = 1'b0;
        n_done   = 1'b0;
        n_res    = '0;
        n_res.entry_count = r_cnt;
        n_res.last        = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    case (i_q_cmd.op)
                        OP_ADD: begin
                            n_done = 1'b1;
                            if (r_cnt == CNT_W'(DEPTH)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                wr_en    = 1'b1;
                                wr_addr  = r_cnt[ADDR_W-1:0];
                                wr_data  = i_q_cmd.rec;
                                n_cnt    = r_cnt + 1'b1;
                                n_sorted = 1'b0;
                                n_res.entry_count = r_cnt + 1'b1;
                            end
                        end
                        OP_UPD: begin
                            if (r_cnt == '0) begin
                                n_done       = 1'b1;
                                n_res.status = ST_NOMATCH;
                            end else begin
                                rd_en   = 1'b1;
                                n_k     = '0;
                                n_state = S_UPD_CHK;
                            end
                        end
                        OP_SCAN: begin
                            if (!r_sorted && r_cnt > CNT_W'(1)) begin
                                rd_en   = 1'b1;
                                rd_addr = ADDR_W'(1);
                                n_i     = CNT_W'(1);
                                n_state = S_SRT_KEY;
                            end else begin
                                n_sorted = 1'b1;
                                if (r_cnt == '0) begin
                                    n_done = 1'b1;
                                end else begin
                                    rd_en   = 1'b1;
                                    n_k     = '0;
                                    n_state = S_SCN_OUT;
                                end
                            end
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end
            S_UPD_CHK: begin
                if (r_rd.inode == r_cmd_rec.inode && r_rd.index == r_cmd_rec.index) begin
                    wr_en         = 1'b1;
                    wr_addr       = r_k[ADDR_W-1:0];
                    wr_data       = r_rd;
                    wr_data.block = r_cmd_rec.block;
                    n_sorted      = 1'b0;
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end else if (r_k + 1'b1 == r_cnt) begin
                    n_done       = 1'b1;
                    n_res.status = ST_NOMATCH;
                    n_state      = S_IDLE;
                end else begin
                    n_k     = r_k + 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = n_k[ADDR_W-1:0];
                end
            end
            S_SRT_KEY: begin
                n_key   = r_rd;
                n_j     = r_i;
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(r_i - 1'b1);
                n_state = S_SRT_CMP;
            end
            S_SRT_CMP: begin
                wr_en   = 1'b1;
                wr_addr = r_j[ADDR_W-1:0];
                if (rec_after(r_rd, r_key)) begin
                    // shift the larger record up one slot
                    wr_data = r_rd;
                    n_j     = r_j - 1'b1;
                    if (n_j == '0) begin
                        n_state = S_SRT_PUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = ADDR_W'(n_j - 1'b1);
                    end
                end else begin
                    n_i = i_nx;
                    rd_en = 1'b1;
                    if (i_nx == r_cnt) begin
                        n_sorted = 1'b1;
                        n_k      = '0;
                        n_state  = S_SCN_OUT;
                    end else begin
                        rd_addr = i_nx[ADDR_W-1:0];
                        n_state = S_SRT_KEY;
                    end
                end
            end
            S_SRT_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_j[ADDR_W-1:0];
                n_i     = i_nx;
                rd_en   = 1'b1;
                if (i_nx == r_cnt) begin
                    n_sorted = 1'b1;
                    n_k      = '0;
                    n_state  = S_SCN_OUT;
                end else begin
                    rd_addr = i_nx[ADDR_W-1:0];
                    n_state = S_SRT_KEY;
                end
            end
            S_SCN_OUT: begin
                n_done            = 1'b1;
                n_res.entry_valid = 1'b1;
                n_res.entry_inode = r_rd.inode;
                n_res.entry_block = r_rd.block;
                n_res.entry_index = r_rd.index;
                n_res.last        = (r_k + 1'b1 == r_cnt);
                if (n_res.last) begin
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = n_k[ADDR_W-1:0];
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            // pass the record being written straight through to the read
            if (wr_en && wr_addr == rd_addr) begin
                r_rd <= wr_data;
            end else begin
                r_rd <= mem[rd_addr];
            end
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_res <= n_res;
        if (o_q_pop) begin
            r_cmd_rec <= i_q_cmd.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_sorted <= 1'b1;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_sorted <= n_sorted;
            r_done   <= n_done;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef ASSERT_OFF
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("record count above capacity");

    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_res.entry_valid |-> r_res.status == ST_OK)
        else $error("scanned record with error status");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_state == S_IDLE)
        else $error("request popped while busy");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != $past(r_cnt) |-> r_cnt == $past(r_cnt) + 1'b1)
        else $error("record count moved by more than one");

    a_sort_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCN_OUT |-> r_sorted)
        else $error("scan emitting from unsorted table");
`endif

endmodule

// ===== hw/rtl/directory_block_table.sv =====
`timescale 1ns / 1ps
// Channel   | Ports                    | Handshake
// ----------+--------------------------+----------------------------------
// request   | start, i_req, busy       | taken when start high, busy low
// result    | o_done, o_result         | registered, no stall
//
// Requests queue two deep ahead of a single execution engine; busy rises
// only when that queue is full. The engine takes a request in S_IDLE,
// then walks the records in turn, searching them on update or emitting
// them on scan; an unsorted scan first runs an insertion sort that moves
// each larger record up one slot. Each result is registered on output.
// Reset (synchronous, active low) empties the table and marks it sorted.

module directory_block_table import dbt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_res o_result
);

    logic q_valid, q_pop;
    t_cmd q_cmd;

    dbt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_req     (i_req),
        .busy      (busy),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    dbt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_done    (o_done),
        .o_result  (o_result)
    );

endmodule
